/* rtl/tfpv_pkg.sv */
`default_nettype none
package tfpv_pkg;

    localparam int POS_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int CMD_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic MODE_AIM  = 1'b0;
    localparam logic MODE_ODOM = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIM  = 3'd6;

    localparam logic [31:0] GAIN_P_RST  = 32'd3355443;
    localparam logic [31:0] GAIN_D_RST  = 32'd8388608;
    localparam logic [31:0] GAIN_I_RST  = 32'd1678;
    localparam logic [30:0] INT_LIM_RST = 31'd32768000;
    localparam logic [18:0] OUT_LIM_RST = 19'd262144;

    localparam logic signed [33:0] COEF_ONE = 34'sd1073741824;

    typedef enum logic [3:0] {
        A_ERR_X, A_ERR_Y, A_CHG_X, A_CHG_Y, A_SUM_X, A_SUM_Y,
        A_QW, A_QX, A_QY, A_QZ,
        A_R00, A_R01, A_R10, A_R11, A_R20, A_R21
    } a_sel_t;

    typedef enum logic [3:0] {
        B_GP_HI, B_GP_LO, B_GD_HI, B_GD_LO, B_GI_HI, B_GI_LO,
        B_QX, B_QY, B_QZ, B_VX, B_VY
    } b_sel_t;

    typedef enum logic [1:0] {G_NONE, G_HI, G_LO} g_op_t;

    typedef enum logic [2:0] {
        V_NONE, V_LOAD_X, V_ADD, V_SUB, V_STX_LDY, V_STORE_Y
    } v_op_t;

    typedef enum logic [2:0] {
        C_NONE, C_LD_T, C_LD_U, C_DIAG, C_PAIR01, C_SUM20, C_DIF21
    } c_op_t;

    typedef enum logic [2:0] {O_NONE, O_LOAD, O_FIN0, O_FIN1, O_FIN2} o_op_t;

    typedef struct packed {
        logic   aim_en;
        logic   quat_en;
        logic   mul_en;
        a_sel_t a_sel;
        b_sel_t b_sel;
        g_op_t  g_op;
        v_op_t  v_op;
        c_op_t  c_op;
        o_op_t  o_op;
    } ctl_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    localparam ctl_t CTL_IDLE = '{
        aim_en:  1'b0,
        quat_en: 1'b0,
        mul_en:  1'b0,
        a_sel:   A_ERR_X,
        b_sel:   B_GP_HI,
        g_op:    G_NONE,
        v_op:    V_NONE,
        c_op:    C_NONE,
        o_op:    O_NONE
    };

endpackage
`default_nettype wire

/* rtl/tfpv_if.sv */
`default_nettype none
interface tfpv_in_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic signed [tfpv_pkg::POS_W-1:0]  aim_x;
    logic signed [tfpv_pkg::POS_W-1:0]  aim_y;
    logic signed [tfpv_pkg::QUAT_W-1:0] quat_w;
    logic signed [tfpv_pkg::QUAT_W-1:0] quat_x;
    logic signed [tfpv_pkg::QUAT_W-1:0] quat_y;
    logic signed [tfpv_pkg::QUAT_W-1:0] quat_z;

    modport source (output valid, mode, aim_x, aim_y, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink (input valid, mode, aim_x, aim_y, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

interface tfpv_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tfpv_pkg::CMD_W-1:0] cmd_x;
    logic signed [tfpv_pkg::CMD_W-1:0] cmd_y;
    logic signed [tfpv_pkg::CMD_W-1:0] cmd_z;

    modport source (output valid, cmd_x, cmd_y, cmd_z, input ready);
    modport sink (input valid, cmd_x, cmd_y, cmd_z, output ready);
endinterface
`default_nettype wire

/* rtl/tfpv_ctrl.sv */
`default_nettype none
module tfpv_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_mode,
    output logic                   in_ready,
    input  wire tfpv_pkg::status_t status,
    output tfpv_pkg::ctl_t         ctl
);

    typedef enum logic {S_IDLE, S_RUN} state_t;

    localparam logic [4:0] LAST_STEP = 5'd27;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;

    function automatic tfpv_pkg::ctl_t mk(
        input logic             mul,
        input tfpv_pkg::a_sel_t a,
        input tfpv_pkg::b_sel_t b,
        input tfpv_pkg::g_op_t  g,
        input tfpv_pkg::v_op_t  v,
        input tfpv_pkg::c_op_t  c,
        input tfpv_pkg::o_op_t  o
    );
        tfpv_pkg::ctl_t r;
        r        = tfpv_pkg::CTL_IDLE;
        r.mul_en = mul;
        r.a_sel  = a;
        r.b_sel  = b;
        r.g_op   = g;
        r.v_op   = v;
        r.c_op   = c;
        r.o_op   = o;
        return r;
    endfunction

    function automatic tfpv_pkg::ctl_t step_ctl(input logic [4:0] step);
        tfpv_pkg::ctl_t r;
        unique case (step)
            5'd0:  r = mk(1'b1, tfpv_pkg::A_ERR_X, tfpv_pkg::B_GP_HI, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd1:  r = mk(1'b1, tfpv_pkg::A_ERR_X, tfpv_pkg::B_GP_LO, tfpv_pkg::G_HI,
                          tfpv_pkg::V_LOAD_X, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd2:  r = mk(1'b1, tfpv_pkg::A_CHG_X, tfpv_pkg::B_GD_HI, tfpv_pkg::G_LO,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd3:  r = mk(1'b1, tfpv_pkg::A_CHG_X, tfpv_pkg::B_GD_LO, tfpv_pkg::G_HI,
                          tfpv_pkg::V_ADD, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd4:  r = mk(1'b1, tfpv_pkg::A_SUM_X, tfpv_pkg::B_GI_HI, tfpv_pkg::G_LO,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd5:  r = mk(1'b1, tfpv_pkg::A_SUM_X, tfpv_pkg::B_GI_LO, tfpv_pkg::G_HI,
                          tfpv_pkg::V_SUB, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd6:  r = mk(1'b1, tfpv_pkg::A_ERR_Y, tfpv_pkg::B_GP_HI, tfpv_pkg::G_LO,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd7:  r = mk(1'b1, tfpv_pkg::A_ERR_Y, tfpv_pkg::B_GP_LO, tfpv_pkg::G_HI,
                          tfpv_pkg::V_ADD, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd8:  r = mk(1'b1, tfpv_pkg::A_CHG_Y, tfpv_pkg::B_GD_HI, tfpv_pkg::G_LO,
                          tfpv_pkg::V_STX_LDY, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd9:  r = mk(1'b1, tfpv_pkg::A_CHG_Y, tfpv_pkg::B_GD_LO, tfpv_pkg::G_HI,
                          tfpv_pkg::V_ADD, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd10: r = mk(1'b1, tfpv_pkg::A_SUM_Y, tfpv_pkg::B_GI_HI, tfpv_pkg::G_LO,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd11: r = mk(1'b1, tfpv_pkg::A_SUM_Y, tfpv_pkg::B_GI_LO, tfpv_pkg::G_HI,
                          tfpv_pkg::V_SUB, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd12: r = mk(1'b1, tfpv_pkg::A_QY, tfpv_pkg::B_QY, tfpv_pkg::G_LO,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_NONE);
            5'd13: r = mk(1'b1, tfpv_pkg::A_QX, tfpv_pkg::B_QX, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_ADD, tfpv_pkg::C_LD_T, tfpv_pkg::O_NONE);
            5'd14: r = mk(1'b1, tfpv_pkg::A_QZ, tfpv_pkg::B_QZ, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_STORE_Y, tfpv_pkg::C_LD_U, tfpv_pkg::O_NONE);
            5'd15: r = mk(1'b1, tfpv_pkg::A_QX, tfpv_pkg::B_QY, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_DIAG, tfpv_pkg::O_NONE);
            5'd16: r = mk(1'b1, tfpv_pkg::A_QW, tfpv_pkg::B_QZ, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_LD_T, tfpv_pkg::O_NONE);
            5'd17: r = mk(1'b1, tfpv_pkg::A_R00, tfpv_pkg::B_VX, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_PAIR01, tfpv_pkg::O_NONE);
            5'd18: r = mk(1'b1, tfpv_pkg::A_R01, tfpv_pkg::B_VY, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_LOAD);
            5'd19: r = mk(1'b1, tfpv_pkg::A_R10, tfpv_pkg::B_VX, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_FIN0);
            5'd20: r = mk(1'b1, tfpv_pkg::A_R11, tfpv_pkg::B_VY, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_LOAD);
            5'd21: r = mk(1'b1, tfpv_pkg::A_QX, tfpv_pkg::B_QZ, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_FIN1);
            5'd22: r = mk(1'b1, tfpv_pkg::A_QW, tfpv_pkg::B_QY, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_LD_T, tfpv_pkg::O_NONE);
            5'd23: r = mk(1'b1, tfpv_pkg::A_QY, tfpv_pkg::B_QZ, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_SUM20, tfpv_pkg::O_NONE);
            5'd24: r = mk(1'b1, tfpv_pkg::A_QW, tfpv_pkg::B_QX, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_LD_T, tfpv_pkg::O_NONE);
            5'd25: r = mk(1'b1, tfpv_pkg::A_R20, tfpv_pkg::B_VX, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_DIF21, tfpv_pkg::O_NONE);
            5'd26: r = mk(1'b1, tfpv_pkg::A_R21, tfpv_pkg::B_VY, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_LOAD);
            5'd27: r = mk(1'b0, tfpv_pkg::A_R21, tfpv_pkg::B_VY, tfpv_pkg::G_NONE,
                          tfpv_pkg::V_NONE, tfpv_pkg::C_NONE, tfpv_pkg::O_FIN2);
            default: r = tfpv_pkg::CTL_IDLE;
        endcase
        return r;
    endfunction

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        ctl        = tfpv_pkg::CTL_IDLE;
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.aim_en  = (in_mode == tfpv_pkg::MODE_AIM);
                    ctl.quat_en = (in_mode == tfpv_pkg::MODE_ODOM);
                    if (in_mode == tfpv_pkg::MODE_ODOM)
                    begin
                        state_next = S_RUN;
                        step_next  = '0;
                    end
                end
            end
            S_RUN:
            begin
                if (step_reg != LAST_STEP)
                begin
                    ctl       = step_ctl(step_reg);
                    step_next = step_reg + 5'd1;
                end
                else if (status.out_free)
                begin
                    ctl        = step_ctl(step_reg);
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/tfpv_datapath.sv */
`default_nettype none
module tfpv_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire tfpv_pkg::ctl_t                       ctl,
    output tfpv_pkg::status_t                         status,
    input  wire logic                                 cfg_we,
    input  wire logic [tfpv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tfpv_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic signed [tfpv_pkg::POS_W-1:0]    aim_x,
    input  wire logic signed [tfpv_pkg::POS_W-1:0]    aim_y,
    input  wire logic signed [tfpv_pkg::QUAT_W-1:0]   quat_w,
    input  wire logic signed [tfpv_pkg::QUAT_W-1:0]   quat_x,
    input  wire logic signed [tfpv_pkg::QUAT_W-1:0]   quat_y,
    input  wire logic signed [tfpv_pkg::QUAT_W-1:0]   quat_z,
    input  wire logic                                 out_ready,
    output logic                                      out_valid,
    output logic signed [tfpv_pkg::CMD_W-1:0]         cmd_x,
    output logic signed [tfpv_pkg::CMD_W-1:0]         cmd_y,
    output logic signed [tfpv_pkg::CMD_W-1:0]         cmd_z
);

    logic        [31:0] gain_p_reg;
    logic        [31:0] gain_d_reg;
    logic        [31:0] gain_i_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic        [30:0] int_lim_reg;
    logic        [18:0] out_lim_reg;

    logic signed [31:0] last_aim_x_reg;
    logic signed [31:0] last_aim_y_reg;
    logic signed [32:0] tvel_x_reg;
    logic signed [32:0] tvel_y_reg;
    logic signed [32:0] err_x_reg;
    logic signed [32:0] err_y_reg;
    logic signed [33:0] chg_x_reg;
    logic signed [33:0] chg_y_reg;
    logic signed [31:0] sum_x_reg;
    logic signed [31:0] sum_y_reg;

    logic signed [15:0] qw_reg;
    logic signed [15:0] qx_reg;
    logic signed [15:0] qy_reg;
    logic signed [15:0] qz_reg;

    logic signed [53:0] p_reg;
    logic signed [67:0] gacc_reg;
    logic signed [45:0] v_reg;
    logic signed [19:0] vx_reg;
    logic signed [19:0] vy_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] u_reg;
    logic signed [33:0] r00_reg;
    logic signed [33:0] r01_reg;
    logic signed [33:0] r10_reg;
    logic signed [33:0] r11_reg;
    logic signed [33:0] r20_reg;
    logic signed [33:0] r21_reg;
    logic signed [54:0] o_reg;
    logic signed [19:0] res0_reg;
    logic signed [19:0] res1_reg;
    logic signed [19:0] cmd_x_reg;
    logic signed [19:0] cmd_y_reg;
    logic signed [19:0] cmd_z_reg;
    logic               out_valid_reg;

    logic signed [32:0] err_x;
    logic signed [32:0] err_y;
    logic signed [33:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [53:0] mul_p;
    logic signed [43:0] term;
    logic signed [31:0] pq;
    logic signed [33:0] cs;
    logic signed [33:0] cd;
    logic signed [33:0] us;
    logic signed [54:0] osum;
    logic signed [19:0] ofin;

    function automatic logic signed [31:0] sat_sum(
        input logic signed [31:0] sum,
        input logic signed [32:0] err,
        input logic        [30:0] lim
    );
        logic signed [33:0] s;
        logic signed [33:0] hi;
        s  = 34'(sum) + 34'(err);
        hi = $signed({3'b000, lim});
        if (s > hi)
            s = hi;
        else if (s < -hi)
            s = -hi;
        return s[31:0];
    endfunction

    function automatic logic signed [19:0] sat_vel(
        input logic signed [45:0] v,
        input logic        [18:0] lim
    );
        logic signed [45:0] r;
        logic signed [45:0] hi;
        r  = v;
        hi = $signed({27'd0, lim});
        if (r > hi)
            r = hi;
        else if (r < -hi)
            r = -hi;
        return r[19:0];
    endfunction

    function automatic logic signed [19:0] sat_out(input logic signed [54:0] s);
        logic signed [24:0] q;
        q = s[54:30];
        if (q > 25'sd524287)
            q = 25'sd524287;
        else if (q < -25'sd524288)
            q = -25'sd524288;
        return q[19:0];
    endfunction

    assign err_x = 33'(aim_x) - 33'(center_x_reg);
    assign err_y = 33'(aim_y) - 33'(center_y_reg);

    always_comb
    begin
        unique case (ctl.a_sel)
            tfpv_pkg::A_ERR_X: mul_a = 34'(err_x_reg);
            tfpv_pkg::A_ERR_Y: mul_a = 34'(err_y_reg);
            tfpv_pkg::A_CHG_X: mul_a = chg_x_reg;
            tfpv_pkg::A_CHG_Y: mul_a = chg_y_reg;
            tfpv_pkg::A_SUM_X: mul_a = 34'(sum_x_reg);
            tfpv_pkg::A_SUM_Y: mul_a = 34'(sum_y_reg);
            tfpv_pkg::A_QW:    mul_a = 34'(qw_reg);
            tfpv_pkg::A_QX:    mul_a = 34'(qx_reg);
            tfpv_pkg::A_QY:    mul_a = 34'(qy_reg);
            tfpv_pkg::A_QZ:    mul_a = 34'(qz_reg);
            tfpv_pkg::A_R00:   mul_a = r00_reg;
            tfpv_pkg::A_R01:   mul_a = r01_reg;
            tfpv_pkg::A_R10:   mul_a = r10_reg;
            tfpv_pkg::A_R11:   mul_a = r11_reg;
            tfpv_pkg::A_R20:   mul_a = r20_reg;
            tfpv_pkg::A_R21:   mul_a = r21_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctl.b_sel)
            tfpv_pkg::B_GP_HI: mul_b = $signed({4'b0000, gain_p_reg[31:16]});
            tfpv_pkg::B_GP_LO: mul_b = $signed({4'b0000, gain_p_reg[15:0]});
            tfpv_pkg::B_GD_HI: mul_b = $signed({4'b0000, gain_d_reg[31:16]});
            tfpv_pkg::B_GD_LO: mul_b = $signed({4'b0000, gain_d_reg[15:0]});
            tfpv_pkg::B_GI_HI: mul_b = $signed({4'b0000, gain_i_reg[31:16]});
            tfpv_pkg::B_GI_LO: mul_b = $signed({4'b0000, gain_i_reg[15:0]});
            tfpv_pkg::B_QX:    mul_b = 20'(qx_reg);
            tfpv_pkg::B_QY:    mul_b = 20'(qy_reg);
            tfpv_pkg::B_QZ:    mul_b = 20'(qz_reg);
            tfpv_pkg::B_VX:    mul_b = vx_reg;
            tfpv_pkg::B_VY:    mul_b = vy_reg;
            default:           mul_b = '0;
        endcase
    end

    assign mul_p = 54'(mul_a) * 54'(mul_b);
    assign term  = $signed(gacc_reg[67:24]);
    assign pq    = $signed(p_reg[31:0]);
    assign cs    = 34'(t_reg) + 34'(pq);
    assign cd    = 34'(t_reg) - 34'(pq);
    assign us    = 34'(u_reg) + 34'(pq);
    assign osum  = o_reg + 55'(p_reg);
    assign ofin  = sat_out(osum);

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign cmd_x           = cmd_x_reg;
    assign cmd_y           = cmd_y_reg;
    assign cmd_z           = cmd_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= tfpv_pkg::GAIN_P_RST;
            gain_d_reg     <= tfpv_pkg::GAIN_D_RST;
            gain_i_reg     <= tfpv_pkg::GAIN_I_RST;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            int_lim_reg    <= tfpv_pkg::INT_LIM_RST;
            out_lim_reg    <= tfpv_pkg::OUT_LIM_RST;
            last_aim_x_reg <= '0;
            last_aim_y_reg <= '0;
            tvel_x_reg     <= '0;
            tvel_y_reg     <= '0;
            err_x_reg      <= '0;
            err_y_reg      <= '0;
            chg_x_reg      <= '0;
            chg_y_reg      <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tfpv_pkg::CFG_GAIN_P:   gain_p_reg   <= cfg_data;
                    tfpv_pkg::CFG_GAIN_D:   gain_d_reg   <= cfg_data;
                    tfpv_pkg::CFG_GAIN_I:   gain_i_reg   <= cfg_data;
                    tfpv_pkg::CFG_CENTER_X: center_x_reg <= $signed(cfg_data);
                    tfpv_pkg::CFG_CENTER_Y: center_y_reg <= $signed(cfg_data);
                    tfpv_pkg::CFG_INT_LIM:  int_lim_reg  <= cfg_data[30:0];
                    tfpv_pkg::CFG_OUT_LIM:  out_lim_reg  <= cfg_data[18:0];
                    default: ;
                endcase
            end
            if (ctl.aim_en)
            begin
                last_aim_x_reg <= aim_x;
                last_aim_y_reg <= aim_y;
                tvel_x_reg     <= 33'(aim_x) - 33'(last_aim_x_reg);
                tvel_y_reg     <= 33'(aim_y) - 33'(last_aim_y_reg);
                err_x_reg      <= err_x;
                err_y_reg      <= err_y;
                chg_x_reg      <= 34'(err_x) - 34'(err_x_reg);
                chg_y_reg      <= 34'(err_y) - 34'(err_y_reg);
                sum_x_reg      <= sat_sum(sum_x_reg, err_x, int_lim_reg);
                sum_y_reg      <= sat_sum(sum_y_reg, err_y, int_lim_reg);
            end
            if (ctl.o_op == tfpv_pkg::O_FIN2)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.quat_en)
        begin
            qw_reg <= quat_w;
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
        end

        if (ctl.mul_en)
            p_reg <= mul_p;

        case (ctl.g_op)
            tfpv_pkg::G_HI: gacc_reg <= 68'(p_reg) <<< 16;
            tfpv_pkg::G_LO: gacc_reg <= gacc_reg + 68'(p_reg);
            default: ;
        endcase

        case (ctl.v_op)
            tfpv_pkg::V_LOAD_X: v_reg <= 46'(tvel_x_reg);
            tfpv_pkg::V_ADD:    v_reg <= v_reg + 46'(term);
            tfpv_pkg::V_SUB:    v_reg <= v_reg - 46'(term);
            tfpv_pkg::V_STX_LDY:
            begin
                vx_reg <= sat_vel(v_reg, out_lim_reg);
                v_reg  <= 46'(tvel_y_reg);
            end
            tfpv_pkg::V_STORE_Y: vy_reg <= sat_vel(v_reg, out_lim_reg);
            default: ;
        endcase

        case (ctl.c_op)
            tfpv_pkg::C_LD_T: t_reg <= pq;
            tfpv_pkg::C_LD_U: u_reg <= pq;
            tfpv_pkg::C_DIAG:
            begin
                r00_reg <= tfpv_pkg::COEF_ONE - (cs <<< 1);
                r11_reg <= tfpv_pkg::COEF_ONE - (us <<< 1);
            end
            tfpv_pkg::C_PAIR01:
            begin
                r01_reg <= cs <<< 1;
                r10_reg <= cd <<< 1;
            end
            tfpv_pkg::C_SUM20: r20_reg <= cs <<< 1;
            tfpv_pkg::C_DIF21: r21_reg <= cd <<< 1;
            default: ;
        endcase

        case (ctl.o_op)
            tfpv_pkg::O_LOAD: o_reg    <= 55'(p_reg);
            tfpv_pkg::O_FIN0: res0_reg <= ofin;
            tfpv_pkg::O_FIN1: res1_reg <= ofin;
            tfpv_pkg::O_FIN2:
            begin
                cmd_x_reg <= res0_reg;
                cmd_y_reg <= res1_reg;
                cmd_z_reg <= ofin;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/target_follow_pid_velocity.sv */
// Aim beat (mode 0): absorbed in its accept cycle, no result, next beat may follow at once.
// Odometry beat (mode 1): the controller steps through its sequence, forming 27 products
// through the single shared 34x20 multiplier, and accepts no new beat until it is idle again.
// The finished result waits in an output register; the last step holds while it is full and not being taken.
// Reset (async, active low): tracker state zero, gains and limits to their defaults,
// controller idle, no result pending.
`default_nettype none
module target_follow_pid_velocity (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    tfpv_in_if.sink                              item,
    tfpv_out_if.source                           result,
    input  wire logic                            cfg_we,
    input  wire logic [tfpv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfpv_pkg::CFG_DATA_W-1:0] cfg_data
);

    tfpv_pkg::ctl_t    ctl;
    tfpv_pkg::status_t status;
    logic              in_ready;
    logic              out_valid;
    logic signed [tfpv_pkg::CMD_W-1:0] cmd_x;
    logic signed [tfpv_pkg::CMD_W-1:0] cmd_y;
    logic signed [tfpv_pkg::CMD_W-1:0] cmd_z;

    tfpv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item.mode),
        .in_ready (in_ready),
        .status   (status),
        .ctl      (ctl)
    );

    tfpv_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .aim_x     (item.aim_x),
        .aim_y     (item.aim_y),
        .quat_w    (item.quat_w),
        .quat_x    (item.quat_x),
        .quat_y    (item.quat_y),
        .quat_z    (item.quat_z),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .cmd_x     (cmd_x),
        .cmd_y     (cmd_y),
        .cmd_z     (cmd_z)
    );

    assign item.ready   = in_ready;
    assign result.valid = out_valid;
    assign result.cmd_x = cmd_x;
    assign result.cmd_y = cmd_y;
    assign result.cmd_z = cmd_z;

endmodule
`default_nettype wire
